// ===== rtl/lru_recency_list_unit_defines.svh =====
// assertion macros used by the recency list controller rtl
`ifndef LRU_RECENCY_LIST_UNIT_DEFINES_SVH
`define LRU_RECENCY_LIST_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define LRL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define LRL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lrl_pkg.sv =====
// package with codes, widths and types of the recency list unit
`timescale 1ns / 1ps
package lrl_pkg;

  localparam int LRL_ENTRIES = 64;

  localparam int OP_W  = 3;
  localparam int IDX_W = 6;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_TOUCH  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  typedef struct packed {
    logic rd_en;
    logic wo_en;
    logic wn_en;
  } lrl_mem_ctl_t;

endpackage

// ===== rtl/lrl_link_mem.sv =====
// link memories: older links and newer links with listed flag
`timescale 1ns / 1ps
module lrl_link_mem #(
  parameter int ENTRIES = lrl_pkg::LRL_ENTRIES,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic                 clk_i,
  input  lrl_pkg::lrl_mem_ctl_t ctl_i,
  input  logic [AW-1:0]        rd_addr_i,
  input  logic [AW-1:0]        wo_addr_i,
  input  logic [AW:0]          wo_data_i,   // {has_older, older}
  input  logic [AW-1:0]        wn_addr_i,
  input  logic [AW+1:0]        wn_data_i,   // {listed, has_newer, newer}
  output logic [AW:0]          rd_older_o,
  output logic [AW+1:0]        rd_newer_o
);
  import lrl_pkg::*;

  logic [AW:0]   older_mem [ENTRIES];
  logic [AW+1:0] newer_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wo_en) begin
      older_mem[wo_addr_i] <= wo_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_older_o <= older_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wn_en) begin
      newer_mem[wn_addr_i] <= wn_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_newer_o <= newer_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/lrl_ctrl.sv =====
// sequencer: reads an entry, unlinks it, pushes it to the front, sweeps on clear and after reset
`timescale 1ns / 1ps
module lrl_ctrl #(
  parameter int ENTRIES = lrl_pkg::LRL_ENTRIES,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [lrl_pkg::OP_W-1:0]  in_op_i,
  input  logic [lrl_pkg::IDX_W-1:0] in_idx_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic [AW-1:0]           head_o,
  output logic [AW-1:0]           tail_o,
  output logic                    empty_o,
  output lrl_pkg::lrl_mem_ctl_t   mem_ctl_o,
  output logic [AW-1:0]           rd_addr_o,
  output logic [AW-1:0]           wo_addr_o,
  output logic [AW:0]             wo_data_o,
  output logic [AW-1:0]           wn_addr_o,
  output logic [AW+1:0]           wn_data_o,
  input  logic [AW:0]             rd_older_i,
  input  logic [AW+1:0]           rd_newer_i
);
  import lrl_pkg::*;

  `include "lru_recency_list_unit_defines.svh"

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EVAL      = 3'd1;
  localparam logic [2:0] S_RELEASE   = 3'd2;
  localparam logic [2:0] S_PUSH_SELF = 3'd3;
  localparam logic [2:0] S_PUSH_HEAD = 3'd4;
  localparam logic [2:0] S_SWEEP     = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [OP_W-1:0] op_q, op_d;
  logic [AW-1:0]   entry_q, entry_d;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   tail_q, tail_d;
  logic            empty_q, empty_d;
  logic [AW-1:0]   link_q, link_d;
  logic [AW-1:0]   sweep_q, sweep_d;
  logic            reply_q, reply_d;

  logic            accept;
  logic            in_range;
  logic            is_push;
  logic            rd_listed;
  logic            rd_has_newer;
  logic            rd_has_older;
  logic [AW-1:0]   rd_newer;
  logic [AW-1:0]   rd_older;

  assign accept       = in_valid_i && in_ready_o;
  assign in_range     = int'(in_idx_i) < ENTRIES;
  assign is_push      = (op_q == OP_INSERT) || (op_q == OP_TOUCH);
  assign rd_listed    = rd_newer_i[AW+1];
  assign rd_has_newer = rd_newer_i[AW];
  assign rd_newer     = rd_newer_i[AW-1:0];
  assign rd_has_older = rd_older_i[AW];
  assign rd_older     = rd_older_i[AW-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign head_o      = head_q;
  assign tail_o      = tail_q;
  assign empty_o     = empty_q;
  assign rd_addr_o   = AW'(in_idx_i);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    entry_d   = entry_q;
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    link_d    = link_q;
    sweep_d   = sweep_q;
    reply_d   = reply_q;
    mem_ctl_o = '0;
    wo_addr_o = entry_q;
    wo_data_o = '0;
    wn_addr_o = entry_q;
    wn_data_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = in_op_i;
          entry_d = AW'(in_idx_i);
          if (in_op_i == OP_CLEAR) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
            sweep_d = '0;
            reply_d = 1'b1;
            state_d = S_SWEEP;
          end else if (in_range && (in_op_i == OP_INSERT || in_op_i == OP_TOUCH ||
                                    in_op_i == OP_REMOVE)) begin
            mem_ctl_o.rd_en = 1'b1;
            state_d         = S_EVAL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_EVAL: begin
        if (is_push && rd_listed && (head_q == entry_q)) begin
          state_d = S_DONE;
        end else if (rd_listed) begin
          // unlink: repair both neighbors in the same cycle
          mem_ctl_o.wo_en = rd_has_newer;
          wo_addr_o       = rd_newer;
          wo_data_o       = {rd_has_older, rd_older};
          mem_ctl_o.wn_en = rd_has_older;
          wn_addr_o       = rd_older;
          wn_data_o       = {1'b1, rd_has_newer, rd_newer};
          if (!rd_has_newer) begin
            head_d = rd_older;
          end
          if (!rd_has_older) begin
            tail_d = rd_newer;
          end
          if (!rd_has_older && !rd_has_newer) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end
          state_d = is_push ? S_PUSH_SELF : S_RELEASE;
        end else begin
          state_d = is_push ? S_PUSH_SELF : S_DONE;
        end
      end
      S_RELEASE: begin
        mem_ctl_o.wn_en = 1'b1;
        wn_data_o       = '0;
        state_d         = S_DONE;
      end
      S_PUSH_SELF: begin
        mem_ctl_o.wn_en = 1'b1;
        wn_data_o       = {1'b1, 1'b0, {AW{1'b0}}};
        mem_ctl_o.wo_en = 1'b1;
        wo_data_o       = empty_q ? '0 : {1'b1, head_q};
        link_d          = head_q;
        if (empty_q) begin
          tail_d = entry_q;
        end
        head_d  = entry_q;
        empty_d = 1'b0;
        state_d = empty_q ? S_DONE : S_PUSH_HEAD;
      end
      S_PUSH_HEAD: begin
        mem_ctl_o.wn_en = 1'b1;
        wn_addr_o       = link_q;
        wn_data_o       = {1'b1, 1'b1, entry_q};
        state_d         = S_DONE;
      end
      S_SWEEP: begin
        mem_ctl_o.wn_en = 1'b1;
        wn_addr_o       = sweep_q;
        wn_data_o       = '0;
        sweep_d         = sweep_q + 1'b1;
        if (sweep_q == AW'(ENTRIES - 1)) begin
          state_d = reply_q ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      sweep_q <= '0;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      sweep_q <= sweep_d;
      reply_q <= reply_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    entry_q <= entry_d;
    link_q  <= link_d;
  end

  `LRL_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, empty_q, (head_q == '0) && (tail_q == '0), "empty list with nonzero head or tail")
  `LRL_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, state_q != S_IDLE, "accepted transaction left block idle")
  `LRL_ASSERT_NOW(a_push_head, clk_i, rst_ni, state_q == S_PUSH_HEAD, !empty_q && (head_q == entry_q), "head not updated before old head link")

endmodule

// ===== rtl/lru_recency_list_unit.sv =====
// top level of the lru recency list unit
//
// channel   direction  tdata fields (lsb first)
// s_axis    in         operation[2:0], entry_index[8:3], zero pad to 16
// m_axis    out        oldest_entry[5:0], oldest_valid[6], newest_entry[12:7],
//                      newest_valid[13], zero pad to 16
//
// one transaction at a time; query and ignored ops go from accept straight to done,
// remove passes at most through eval and release, insert and touch through eval,
// push_self and push_head, as the newer-link memory has a single write port
// on clear and after reset a sweep over all ENTRIES entries clears the listed flags,
// no input taken; the result sits in an output register, so a stalled m_axis still
// lets the next op be accepted, but its result then waits and blocks later accepts
`timescale 1ns / 1ps
module lru_recency_list_unit #(
  parameter int ENTRIES = lrl_pkg::LRL_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lrl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // operation, entry_index
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lrl_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // oldest_entry, oldest_valid,
                                                         // newest_entry, newest_valid
);
  import lrl_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  lrl_mem_ctl_t  mem_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wo_addr;
  logic [AW:0]   wo_data;
  logic [AW-1:0] wn_addr;
  logic [AW+1:0] wn_data;
  logic [AW:0]   rd_older;
  logic [AW+1:0] rd_newer;

  logic          res_valid;
  logic          res_ready;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic          empty;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  lrl_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tdata[OP_W-1:0]),
    .in_idx_i    (s_axis_tdata[OP_W+IDX_W-1:OP_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .head_o      (head),
    .tail_o      (tail),
    .empty_o     (empty),
    .mem_ctl_o   (mem_ctl),
    .rd_addr_o   (rd_addr),
    .wo_addr_o   (wo_addr),
    .wo_data_o   (wo_data),
    .wn_addr_o   (wn_addr),
    .wn_data_o   (wn_data),
    .rd_older_i  (rd_older),
    .rd_newer_i  (rd_newer)
  );

  lrl_link_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_link_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .wo_addr_i  (wo_addr),
    .wo_data_i  (wo_data),
    .wn_addr_i  (wn_addr),
    .wn_data_i  (wn_data),
    .rd_older_o (rd_older),
    .rd_newer_o (rd_newer)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {2'b00, !empty, IDX_W'(head), !empty, IDX_W'(tail)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== tb/sv/lru_recency_list_unit_test.sv =====
// self-checking testbench for the lru recency list unit, with a linked-list recency predictor
`timescale 1ns / 1ps
module lru_recency_list_unit_test;
  import lrl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam int TARGET_ITEMS = 1700;

  typedef struct packed {
    logic             newest_valid;
    logic [IDX_W-1:0] newest_entry;
    logic             oldest_valid;
    logic [IDX_W-1:0] oldest_entry;
  } recency_view_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // operation, entry_index
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // oldest_entry, oldest_valid,
                                          // newest_entry, newest_valid

  // predictor state
  logic [IDX_W-1:0] older_of [LRL_ENTRIES];
  logic [IDX_W-1:0] newer_of [LRL_ENTRIES];
  logic             older_ok [LRL_ENTRIES];
  logic             newer_ok [LRL_ENTRIES];
  logic             in_list  [LRL_ENTRIES];
  logic [IDX_W-1:0] mru_entry;
  logic [IDX_W-1:0] lru_entry;
  logic             list_is_empty;

  recency_view_t    pending_views[$];
  int               err_count;
  int               sent_count;
  bit               idle_on;

  lru_recency_list_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("lru_recency_list_unit_test: done, errors");
    $finish;
  end

  function automatic void recency_empty();
    mru_entry     = '0;
    lru_entry     = '0;
    list_is_empty = 1'b1;
  endfunction

  function automatic void recency_unlink(input logic [IDX_W-1:0] e);
    logic [IDX_W-1:0] o;
    logic [IDX_W-1:0] n;
    logic             ho;
    logic             hn;
    o  = older_of[e];
    n  = newer_of[e];
    ho = older_ok[e];
    hn = newer_ok[e];
    if (hn) begin
      older_of[n] = o;
      older_ok[n] = ho;
    end else begin
      mru_entry = o;
    end
    if (ho) begin
      newer_of[o] = n;
      newer_ok[o] = hn;
    end else begin
      lru_entry = n;
    end
    if (!ho && !hn) begin
      recency_empty();
    end
    older_ok[e] = 1'b0;
    newer_ok[e] = 1'b0;
    in_list[e]  = 1'b0;
  endfunction

  function automatic void recency_push_front(input logic [IDX_W-1:0] e);
    newer_ok[e] = 1'b0;
    newer_of[e] = '0;
    if (list_is_empty) begin
      older_ok[e] = 1'b0;
      older_of[e] = '0;
      lru_entry   = e;
    end else begin
      older_of[e]         = mru_entry;
      older_ok[e]         = 1'b1;
      newer_of[mru_entry] = e;
      newer_ok[mru_entry] = 1'b1;
    end
    mru_entry     = e;
    list_is_empty = 1'b0;
    in_list[e]    = 1'b1;
  endfunction

  function automatic recency_view_t recency_apply(input logic [OP_W-1:0] op,
                                                  input logic [IDX_W-1:0] e);
    recency_view_t v;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < LRL_ENTRIES; i++) in_list[i] = 1'b0;
      recency_empty();
    end else if (op == OP_INSERT || op == OP_TOUCH) begin
      if (!(in_list[e] && !list_is_empty && mru_entry == e)) begin
        if (in_list[e]) recency_unlink(e);
        recency_push_front(e);
      end
    end else if (op == OP_REMOVE) begin
      if (in_list[e]) recency_unlink(e);
    end
    v = '0;
    if (!list_is_empty) begin
      v.oldest_entry = lru_entry;
      v.oldest_valid = 1'b1;
      v.newest_entry = mru_entry;
      v.newest_valid = 1'b1;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic int pick_idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // source side: valid stays high across back-to-back transactions unless an idle gap is drawn
  task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] e);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 40) ? pick_idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= IN_TDATA_W'({e, op});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_views.push_back(recency_apply(op, e));
    sent_count++;
    @(negedge clk_i);
  endtask

  // sink side
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        repeat (pick_idle_len()) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    recency_view_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        want = pending_views.pop_front();
        if (m_axis_tdata[5:0] !== want.oldest_entry)
          report_mismatch("oldest_entry", m_axis_tdata[5:0], want.oldest_entry);
        if (m_axis_tdata[6] !== want.oldest_valid)
          report_mismatch("oldest_valid", m_axis_tdata[6], want.oldest_valid);
        if (m_axis_tdata[12:7] !== want.newest_entry)
          report_mismatch("newest_entry", m_axis_tdata[12:7], want.newest_entry);
        if (m_axis_tdata[13] !== want.newest_valid)
          report_mismatch("newest_valid", m_axis_tdata[13], want.newest_valid);
        if (m_axis_tdata[15:14] !== 2'b00)
          report_mismatch("tdata pad", m_axis_tdata[15:14], 0);
      end
    end
  end

  task automatic test_empty_list();
    send_op(OP_QUERY, 6'd0);
    send_op(OP_REMOVE, 6'd0);
    send_op(OP_UNUSED_5, 6'd63);
    send_op(OP_UNUSED_7, 6'd42);
  endtask

  task automatic test_front_and_back();
    send_op(OP_INSERT, 6'd0);
    send_op(OP_INSERT, 6'd63);
    send_op(OP_TOUCH, 6'd0);    // tail to head
    send_op(OP_TOUCH, 6'd0);    // head, no change
    send_op(OP_INSERT, 6'd21);
    send_op(OP_REMOVE, 6'd63);  // tail
    send_op(OP_REMOVE, 6'd21);  // head
    send_op(OP_REMOVE, 6'd0);   // last entry
  endtask

  task automatic test_repairs();
    send_op(OP_INSERT, 6'd5);
    send_op(OP_INSERT, 6'd5);   // listed head
    send_op(OP_INSERT, 6'd9);
    send_op(OP_INSERT, 6'd5);   // listed, not head
    send_op(OP_TOUCH, 6'd40);   // unlisted
    send_op(OP_REMOVE, 6'd33);  // unlisted
    send_op(OP_UNUSED_6, 6'd5);
    send_op(OP_REMOVE, 6'd9);   // tail
  endtask

  task automatic test_clear();
    send_op(OP_CLEAR, 6'd63);
    send_op(OP_QUERY, 6'd63);
    send_op(OP_INSERT, 6'd42);
    send_op(OP_QUERY, 6'd0);
  endtask

  task automatic test_full_list();
    int order[LRL_ENTRIES];
    int j;
    int tmp;
    for (int i = 0; i < LRL_ENTRIES; i++) order[i] = i;
    for (int i = LRL_ENTRIES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < LRL_ENTRIES; i++) send_op(OP_INSERT, IDX_W'(order[i]));
    repeat (40) send_op(($urandom_range(0, 1) != 0) ? OP_TOUCH : OP_INSERT,
                        IDX_W'($urandom_range(0, LRL_ENTRIES - 1)));
    for (int i = LRL_ENTRIES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < LRL_ENTRIES; i++) send_op(OP_REMOVE, IDX_W'(order[i]));
  endtask

  // segments of traffic on a random pool of entries, so hits on listed entries are common
  task automatic test_random_traffic();
    logic [IDX_W-1:0] pool[LRL_ENTRIES];
    int               pool_n;
    int               seg_len;
    int               r;
    logic [OP_W-1:0]  op;
    while (sent_count < TARGET_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pool_n  = ($urandom_range(0, 3) == 0) ? $urandom_range(16, LRL_ENTRIES)
                                            : $urandom_range(2, 10);
      for (int i = 0; i < pool_n; i++) pool[i] = IDX_W'($urandom_range(0, LRL_ENTRIES - 1));
      seg_len = $urandom_range(30, 80);
      for (int k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 32)      op = OP_INSERT;
        else if (r < 58) op = OP_TOUCH;
        else if (r < 88) op = OP_REMOVE;
        else if (r < 93) op = OP_QUERY;
        else if (r < 94) op = OP_UNUSED_5;
        else if (r < 95) op = OP_UNUSED_6;
        else if (r < 96) op = OP_UNUSED_7;
        else if (r < 98) op = OP_CLEAR;
        else             op = OP_REMOVE;
        if ($urandom_range(0, 9) == 0)
          send_op(op, IDX_W'($urandom_range(0, LRL_ENTRIES - 1)));
        else
          send_op(op, pool[$urandom_range(0, pool_n - 1)]);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_on       = 1'b1;
    err_count     = 0;
    sent_count    = 0;
    for (int i = 0; i < LRL_ENTRIES; i++) begin
      in_list[i]  = 1'b0;
      older_ok[i] = 1'b0;
      newer_ok[i] = 1'b0;
      older_of[i] = '0;
      newer_of[i] = '0;
    end
    recency_empty();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_front_and_back();
    test_repairs();
    test_clear();
    test_full_list();
    test_random_traffic();

    s_axis_tvalid <= 1'b0;
    wait (pending_views.size() == 0);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("lru_recency_list_unit_test: done, clean");
    end else begin
      $display("lru_recency_list_unit_test: done, errors");
    end
    $finish;
  end

endmodule
